// ===== hw/rtl/tpti_pkg.sv =====
// ----------------------------------------------------------------------------
// tpti_pkg
// shared types, codes and helpers of the terrain patch triangle indexer
// ----------------------------------------------------------------------------
package tpti_pkg;

   localparam int CountW   = 7;   // cell count and step registers
   localparam int MaskW    = 8;   // edge stitch mask register
   localparam int CoordW   = 6;   // coarse cell column and row
   localparam int PosW     = 7;   // vertex coordinate, 0..count
   localparam int GridW    = 8;   // vertices per row, count + 1
   localparam int LogW     = 3;   // log2 of the step
   localparam int IdxW     = 13;  // vertex index
   localparam int ProdW    = PosW + GridW;
   localparam int CsrIdxW  = 2;
   localparam int CsrDataW = 8;
   localparam int NumCorner = 4;

   localparam int EdgeNorth = 0;
   localparam int EdgeSouth = 1;
   localparam int EdgeEast  = 2;
   localparam int EdgeWest  = 3;
   localparam logic [MaskW-1:0] EdgeAll = 8'h0f;

   localparam logic [CountW-1:0] ResetCells = 7'd64;
   localparam logic [CountW-1:0] ResetStep  = 7'd1;
   localparam logic [MaskW-1:0]  ResetMask  = 8'h00;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_BAD_KEY = 2'd1,
      STATUS_OUTSIDE = 2'd2
   } status_type;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_CELLS_WIDE  = 2'd0,
      CSR_CELLS_TALL  = 2'd1,
      CSR_DETAIL_STEP = 2'd2,
      CSR_EDGE_MASK   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [CoordW-1:0] cell_col;
      logic [CoordW-1:0] cell_row;
   } req_type;

   typedef struct packed {
      status_type      status;
      logic            first_valid;
      logic [IdxW-1:0] first_i0;
      logic [IdxW-1:0] first_i1;
      logic [IdxW-1:0] first_i2;
      logic            second_valid;
      logic [IdxW-1:0] second_i0;
      logic [IdxW-1:0] second_i1;
      logic [IdxW-1:0] second_i2;
   } rsp_type;

   // decoded patch configuration
   typedef struct packed {
      logic              key_ok;
      logic [PosW-1:0]   cx;
      logic [PosW-1:0]   cy;
      logic [GridW-1:0]  width;
      logic [3:0]        mask;
   } geom_cfg_type;

   typedef struct packed {
      logic [PosW-1:0] x;
      logic [PosW-1:0] y;
   } vtx_type;

   // corner stage payload: a, b, c, d corners after snapping
   typedef struct packed {
      status_type                 status;
      vtx_type [NumCorner-1:0]    corner;
   } corner_type;

   // geometry stage payload
   typedef struct packed {
      status_type                       status;
      logic [1:0]                       area_pos;
      logic [1:0]                       area_neg;
      logic [NumCorner-1:0][IdxW-1:0]   idx;
   } geom_type;

   // snap along stitched edges, applied in north, south, east, west order
   function automatic vtx_type snap_vertex(vtx_type v, logic [PosW-1:0] cx,
                                           logic [PosW-1:0] cy, logic [3:0] mask);
      vtx_type r;
      r = v;
      if (r.y == '0 && mask[EdgeNorth] && r.x[0]) r.x = r.x - 7'd1;
      if (r.y == cy && mask[EdgeSouth] && r.x[0]) r.x = r.x - 7'd1;
      if (r.x == cx && mask[EdgeEast] && r.y[0]) r.y = r.y - 7'd1;
      if (r.x == '0 && mask[EdgeWest] && r.y[0]) r.y = r.y - 7'd1;
      return r;
   endfunction

endpackage

// ===== hw/rtl/tpti_cfg.sv =====
// ----------------------------------------------------------------------------
// tpti_cfg
// configuration registers and decode of the patch key
// ----------------------------------------------------------------------------
module tpti_cfg #(
   parameter int MAX_CELLS = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [tpti_pkg::CsrIdxW-1:0]    csr_index,
   input  logic [tpti_pkg::CsrDataW-1:0]   csr_wdata,
   output tpti_pkg::geom_cfg_type          cfg
);

   localparam logic [tpti_pkg::CountW:0] MaxCount = (tpti_pkg::CountW+1)'(MAX_CELLS);

   logic [tpti_pkg::CountW-1:0] cells_wide_ff, cells_tall_ff, detail_step_ff;
   logic [tpti_pkg::MaskW-1:0]  edge_mask_ff;

   logic [tpti_pkg::CountW-1:0] step_m1;
   logic [tpti_pkg::LogW-1:0]   step_log;
   logic                        step_pow2;
   logic                        range_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         cells_wide_ff  <= tpti_pkg::ResetCells;
         cells_tall_ff  <= tpti_pkg::ResetCells;
         detail_step_ff <= tpti_pkg::ResetStep;
         edge_mask_ff   <= tpti_pkg::ResetMask;
      end else if (csr_we) begin
         case (tpti_pkg::csr_index_type'(csr_index))
            tpti_pkg::CSR_CELLS_WIDE:  cells_wide_ff  <= csr_wdata[tpti_pkg::CountW-1:0];
            tpti_pkg::CSR_CELLS_TALL:  cells_tall_ff  <= csr_wdata[tpti_pkg::CountW-1:0];
            tpti_pkg::CSR_DETAIL_STEP: detail_step_ff <= csr_wdata[tpti_pkg::CountW-1:0];
            tpti_pkg::CSR_EDGE_MASK:   edge_mask_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // decode follows the registers directly, so the cell right after a write sees it
   always_comb begin
      step_m1   = detail_step_ff - 7'd1;
      step_pow2 = (detail_step_ff != '0) && ((detail_step_ff & step_m1) == '0);
      step_log  = '0;
      for (int i = 0; i < tpti_pkg::CountW; i++) begin
         if (detail_step_ff[i]) step_log = tpti_pkg::LogW'(i);
      end
      range_ok = (cells_wide_ff != '0) && (cells_tall_ff != '0)
               && ({1'b0, cells_wide_ff} <= MaxCount) && ({1'b0, cells_tall_ff} <= MaxCount)
               && ({1'b0, detail_step_ff} <= MaxCount) && step_pow2
               && ((cells_wide_ff & step_m1) == '0) && ((cells_tall_ff & step_m1) == '0)
               && ((edge_mask_ff & ~tpti_pkg::EdgeAll) == '0);
      cfg.cx     = cells_wide_ff >> step_log;
      cfg.cy     = cells_tall_ff >> step_log;
      cfg.width  = {1'b0, cfg.cx} + 8'd1;
      cfg.mask   = edge_mask_ff[3:0];
      cfg.key_ok = range_ok
         && !((edge_mask_ff[tpti_pkg::EdgeNorth] || edge_mask_ff[tpti_pkg::EdgeSouth])
              && cfg.cx[0])
         && !((edge_mask_ff[tpti_pkg::EdgeEast] || edge_mask_ff[tpti_pkg::EdgeWest])
              && cfg.cy[0]);
   end

endmodule

// ===== hw/rtl/tpti_corner.sv =====
// ----------------------------------------------------------------------------
// tpti_corner
// first stage: key and range check, cell corners and edge snapping
// ----------------------------------------------------------------------------
module tpti_corner (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  tpti_pkg::req_type       req,
   input  tpti_pkg::geom_cfg_type  cfg,
   output logic                    out_valid,
   output tpti_pkg::corner_type    out_data
);

   logic                  valid_ff;
   tpti_pkg::corner_type  data_ff, data_in;
   tpti_pkg::vtx_type     raw [tpti_pkg::NumCorner];
   logic [tpti_pkg::PosW-1:0] x0, y0;

   always_comb begin
      x0 = {1'b0, req.cell_col};
      y0 = {1'b0, req.cell_row};
      raw[0] = '{x: x0,        y: y0};
      raw[1] = '{x: x0 + 7'd1, y: y0};
      raw[2] = '{x: x0,        y: y0 + 7'd1};
      raw[3] = '{x: x0 + 7'd1, y: y0 + 7'd1};
      for (int k = 0; k < tpti_pkg::NumCorner; k++) begin
         data_in.corner[k] = tpti_pkg::snap_vertex(raw[k], cfg.cx, cfg.cy, cfg.mask);
      end
      if (!cfg.key_ok) begin
         data_in.status = tpti_pkg::STATUS_BAD_KEY;
      end else if (x0 >= cfg.cx || y0 >= cfg.cy) begin
         data_in.status = tpti_pkg::STATUS_OUTSIDE;
      end else begin
         data_in.status = tpti_pkg::STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== hw/rtl/tpti_geom.sv =====
// ----------------------------------------------------------------------------
// tpti_geom
// second stage: cross product signs and linear vertex indices
// ----------------------------------------------------------------------------
module tpti_geom (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  tpti_pkg::corner_type    in_data,
   input  tpti_pkg::geom_cfg_type  cfg,
   output logic                    out_valid,
   output tpti_pkg::geom_type      out_data
);

   logic                 valid_ff;
   tpti_pkg::geom_type   data_ff, data_in;
   logic signed [16:0]   area_first, area_second;
   logic [tpti_pkg::ProdW-1:0] row_base [tpti_pkg::NumCorner];

   function automatic logic signed [16:0] twice_area(tpti_pkg::vtx_type a,
                                                     tpti_pkg::vtx_type b,
                                                     tpti_pkg::vtx_type c);
      logic signed [7:0]  bx, by, cxd, cyd;
      logic signed [15:0] p0, p1;
      bx  = $signed({1'b0, b.x}) - $signed({1'b0, a.x});
      by  = $signed({1'b0, b.y}) - $signed({1'b0, a.y});
      cxd = $signed({1'b0, c.x}) - $signed({1'b0, a.x});
      cyd = $signed({1'b0, c.y}) - $signed({1'b0, a.y});
      p0  = bx * cyd;
      p1  = by * cxd;
      return 17'(p0) - 17'(p1);
   endfunction

   always_comb begin
      area_first  = twice_area(in_data.corner[0], in_data.corner[1], in_data.corner[2]);
      area_second = twice_area(in_data.corner[1], in_data.corner[3], in_data.corner[2]);
      data_in.status      = in_data.status;
      data_in.area_pos[0] = !area_first[16] && (area_first != '0);
      data_in.area_neg[0] = area_first[16];
      data_in.area_pos[1] = !area_second[16] && (area_second != '0);
      data_in.area_neg[1] = area_second[16];
      for (int k = 0; k < tpti_pkg::NumCorner; k++) begin
         row_base[k] = tpti_pkg::ProdW'(in_data.corner[k].y)
                     * tpti_pkg::ProdW'(cfg.width)
                     + tpti_pkg::ProdW'(in_data.corner[k].x);
         data_in.idx[k] = row_base[k][tpti_pkg::IdxW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== hw/rtl/tpti_wind.sv =====
// ----------------------------------------------------------------------------
// tpti_wind
// third stage: winding, dropped triangles and the result register
// ----------------------------------------------------------------------------
module tpti_wind (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  tpti_pkg::geom_type    in_data,
   output logic                  rsp_valid,
   output tpti_pkg::rsp_type     rsp_data
);

   logic               valid_ff;
   tpti_pkg::rsp_type  rsp_ff, rsp_in;
   logic               ok;

   always_comb begin
      rsp_in        = '0;
      rsp_in.status = in_data.status;
      ok            = (in_data.status == tpti_pkg::STATUS_OK);
      if (ok && in_data.area_pos[0]) begin
         rsp_in.first_valid = 1'b1;
         rsp_in.first_i0    = in_data.idx[0];
         rsp_in.first_i1    = in_data.idx[1];
         rsp_in.first_i2    = in_data.idx[2];
      end else if (ok && in_data.area_neg[0]) begin
         rsp_in.first_valid = 1'b1;
         rsp_in.first_i0    = in_data.idx[0];
         rsp_in.first_i1    = in_data.idx[2];
         rsp_in.first_i2    = in_data.idx[1];
      end
      if (ok && in_data.area_pos[1]) begin
         rsp_in.second_valid = 1'b1;
         rsp_in.second_i0    = in_data.idx[1];
         rsp_in.second_i1    = in_data.idx[3];
         rsp_in.second_i2    = in_data.idx[2];
      end else if (ok && in_data.area_neg[1]) begin
         rsp_in.second_valid = 1'b1;
         rsp_in.second_i0    = in_data.idx[1];
         rsp_in.second_i1    = in_data.idx[2];
         rsp_in.second_i2    = in_data.idx[3];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== hw/rtl/terrain_patch_triangle_indexer_unit.sv =====
// ----------------------------------------------------------------------------
// terrain_patch_triangle_indexer_unit
// result: an accepted transaction shows on rsp_valid/rsp_data for one cycle,
//   after the corner, geom and wind registers (three register stages)
// throughput: one cell per cycle, busy stays low, every start is taken
// reset: synchronous, active high; clears stage valid bits and restores
//   the patch registers to 64 x 64 cells, step 1, no stitched edges
// the receiver cannot stall, so no backpressure path exists
// ----------------------------------------------------------------------------
module terrain_patch_triangle_indexer_unit #(
   parameter int MAX_CELLS = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   // cell request
   input  logic                            start,
   output logic                            busy,
   input  tpti_pkg::req_type               req_cell,
   // triangle result
   output logic                            rsp_valid,
   output tpti_pkg::rsp_type               rsp_data,
   // configuration writes
   input  logic                            csr_we,
   input  logic [tpti_pkg::CsrIdxW-1:0]    csr_index,
   input  logic [tpti_pkg::CsrDataW-1:0]   csr_wdata
);

   tpti_pkg::geom_cfg_type  cfg;
   logic                    accept;
   logic                    s1_valid, s2_valid;
   tpti_pkg::corner_type    s1_data;
   tpti_pkg::geom_type      s2_data;

   // every stage advances every cycle, so a new cell is always welcome
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // patch registers; decode (coarse counts, row pitch, key check) follows
   // the registers; the user must write configuration only while the pipe is empty, the block does not enforce it
   tpti_cfg #(
      .MAX_CELLS (MAX_CELLS)
   ) u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // stage 1: status, four corners, stitched edge snapping
   tpti_corner u_corner (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .req       (req_cell),
      .cfg       (cfg),
      .out_valid (s1_valid),
      .out_data  (s1_data)
   );

   // stage 2: cross product sign per triangle, row * pitch + column indices
   tpti_geom u_geom (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_data   (s1_data),
      .cfg       (cfg),
      .out_valid (s2_valid),
      .out_data  (s2_data)
   );

   // stage 3: counter-clockwise winding, zero-area drop, result register
   tpti_wind u_wind (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .in_data   (s2_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== hw/rtl/tpti_checker.sv =====
// ----------------------------------------------------------------------------
// tpti_checker
// port-level checks of the triangle indexer, bound to the top level
// ----------------------------------------------------------------------------
module tpti_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input tpti_pkg::rsp_type  rsp_data,
   input logic               rsp_valid
);

   // every accepted transaction produces a result
   a_accept_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##3 rsp_valid)
      else $error("accepted cell produced no result");

   // no result without an earlier accepted transaction
   a_rsp_from_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 3))
      else $error("result without a matching request");

   // a failed check carries no triangles
   a_error_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != tpti_pkg::STATUS_OK)
      |-> (!rsp_data.first_valid && !rsp_data.second_valid
           && rsp_data.first_i0 == '0 && rsp_data.second_i0 == '0))
      else $error("triangle emitted with error status");

   // an emitted first triangle has nonzero area, so its corners differ
   a_distinct_corners: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.first_valid)
      |-> (rsp_data.first_i0 != rsp_data.first_i1
           && rsp_data.first_i1 != rsp_data.first_i2
           && rsp_data.first_i0 != rsp_data.first_i2))
      else $error("degenerate first triangle emitted");

endmodule

bind terrain_patch_triangle_indexer_unit tpti_checker u_tpti_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_data  (rsp_data),
   .rsp_valid (rsp_valid)
);
